@@ hdl/nadg_pkg.sv @@
// Shared types, field widths and register codes for the 3x3 neighbour gradient block.
package nadg_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_PIXEL_BITS = 16;

	localparam int unsigned PIX_W       = 16;
	localparam int unsigned GRAD_W      = 19;
	localparam int unsigned WIDTH_REG_W = 11;
	localparam int unsigned HEIGHT_W    = 16;
	localparam int unsigned MASK_W      = 8;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned NBR_COUNT   = 8;

	localparam logic [GRAD_W-1:0]      GRAD_MAX   = '1;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST  = WIDTH_REG_W'(1024);
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RST = HEIGHT_W'(1024);
	localparam logic [MASK_W-1:0]      MASK_RST   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_IMAGE_HEIGHT   = 2'd1,
		REG_NEIGHBOUR_MASK = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             mode;
		logic [PIX_W-1:0] pixel;
	} pix_word_t;

	typedef struct packed {
		logic [GRAD_W-1:0] gradient;
		logic              last_of_frame;
	} res_word_t;

	// Border and framing flags that travel with one pixel down the pipeline
	typedef struct packed {
		logic emit;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} nbr_flags_t;

endpackage

@@ hdl/neighbour_abs_diff_gradient.sv @@
// Top level: streaming 3x3 masked sum-of-absolute-differences gradient.
//
//   port group  dir  handshake              word
//   pix         in   pix_valid/pix_ready    pix_word_t {mode, pixel}
//   res         out  res_valid/res_ready    res_word_t {gradient, last_of_frame}
//   cfg         in   cfg_wr_en              cfg_index, cfg_data
//
// One word per cycle in and out while res_ready is high. A word passes an input stage (line store read),
// the window stage and the result register, each registered, in that order.
// A result appears image_width+1 words after its pixel; flush words drain the tail.
// Reset clears the counters, window and valid flags; the line store needs no clear.
// A held result stalls only as far back as the first empty stage.
module neighbour_abs_diff_gradient import nadg_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_word_t             pix,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_word_t             res,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);

	logic [WCNT_W-1:0]       width_eff;
	logic [HEIGHT_W-1:0]     height_eff;
	logic [MASK_W-1:0]       mask;
	logic                    restart;
	logic [COL_W-1:0]        col;
	nbr_flags_t              flags;
	logic                    accept;
	logic                    leave_s1;
	logic                    s2_ready;
	logic [PIXEL_BITS-1:0]   pixel_in;
	logic [2*PIXEL_BITS-1:0] lines;
	logic [PIXEL_BITS-1:0]   older;
	logic [PIXEL_BITS-1:0]   newer;

	logic                    valid_s1;
	logic [PIXEL_BITS-1:0]   pixel_s1;
	logic [COL_W-1:0]        col_s1;
	nbr_flags_t              flags_s1;

	nadg_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.mask       (mask),
		.restart    (restart)
	);

	nadg_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.restart    (restart),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.col        (col),
		.flags      (flags)
	);

	assign pix_ready = !valid_s1 || s2_ready;
	assign accept    = pix_valid && pix_ready;
	assign leave_s1  = valid_s1 && s2_ready;

	// flush words enter as zero pixels
	assign pixel_in = pix.mode ? '0 : PIXEL_BITS'(pix.pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel_in;
			col_s1   <= col;
			flags_s1 <= flags;
		end
	end

	nadg_line_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_lines (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (leave_s1),
		.wr_addr (col_s1),
		.wr_data ({newer, pixel_s1}),
		.rd_data (lines)
	);

	assign older = lines[2*PIXEL_BITS-1:PIXEL_BITS];
	assign newer = lines[PIXEL_BITS-1:0];

	nadg_sad #(.PIXEL_BITS(PIXEL_BITS)) u_sad (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (leave_s1),
		.older     (older),
		.newer     (newer),
		.pixel_s1  (pixel_s1),
		.flags_s1  (flags_s1),
		.mask      (mask),
		.s2_ready  (s2_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

@@ hdl/nadg_cfg.sv @@
// Configuration registers and effective frame geometry.
module nadg_cfg import nadg_pkg::*; #(
	parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [WCNT_W-1:0]     width_eff,
	output logic [HEIGHT_W-1:0]   height_eff,
	output logic [MASK_W-1:0]     mask,
	output logic                  restart
);

	localparam int unsigned CMP_W = (WCNT_W > WIDTH_REG_W) ? WCNT_W : WIDTH_REG_W;

	logic [WIDTH_REG_W-1:0] image_width_q;
	logic [HEIGHT_W-1:0]    image_height_q;
	logic [MASK_W-1:0]      mask_q;
	logic [CMP_W-1:0]       width_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
			mask_q         <= MASK_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:    image_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q <= cfg_data[HEIGHT_W-1:0];
				REG_NEIGHBOUR_MASK: mask_q         <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// a geometry write starts a new frame
	assign restart = cfg_wr_en &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	assign width_raw = CMP_W'(image_width_q);

	always_comb begin
		if (width_raw == '0) begin
			width_eff = WCNT_W'(1);
		end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
			width_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			width_eff = WCNT_W'(width_raw);
		end
	end

	assign height_eff = (image_height_q == '0) ? HEIGHT_W'(1) : image_height_q;
	assign mask       = mask_q;

endmodule

@@ hdl/nadg_pos.sv @@
// Input and result position counters, border flags and frame wrap.
module nadg_pos import nadg_pkg::*; #(
	parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int unsigned COL_W  = $clog2(MAX_WIDTH),
	localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                restart,
	input  logic [WCNT_W-1:0]   width_eff,
	input  logic [HEIGHT_W-1:0] height_eff,
	output logic [COL_W-1:0]    col,
	output nbr_flags_t          flags
);

	logic [COL_W-1:0]    in_col_q;
	logic [1:0]          in_row_q;   // saturates at two rows
	logic [COL_W-1:0]    out_col_q;
	logic [HEIGHT_W-1:0] out_row_q;
	logic                in_wrap;

	assign col     = in_col_q;
	assign in_wrap = (WCNT_W'(in_col_q) + WCNT_W'(1)) >= width_eff;

	always_comb begin
		flags.emit     = (in_row_q == 2'd2) || (in_row_q == 2'd1 && in_col_q != '0);
		flags.top_ok   = out_row_q != '0;
		flags.bot_ok   = ((HEIGHT_W+1)'(out_row_q) + (HEIGHT_W+1)'(1)) <
			(HEIGHT_W+1)'(height_eff);
		flags.left_ok  = out_col_q != '0;
		flags.right_ok = (WCNT_W'(out_col_q) + WCNT_W'(1)) < width_eff;
		flags.last     = !flags.bot_ok && !flags.right_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (step) begin
			if (in_wrap) begin
				in_col_q <= '0;
				if (in_row_q != 2'd2) begin
					in_row_q <= in_row_q + 2'd1;
				end
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (flags.emit) begin
				if (flags.last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (!flags.right_ok) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HEIGHT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

@@ hdl/nadg_line_store.sv @@
// Two line stores packed in one memory word, with write-to-read bypass.
module nadg_line_store import nadg_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int unsigned COL_W = $clog2(MAX_WIDTH),
	localparam int unsigned WORD_W = 2 * PIXEL_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [COL_W-1:0]  rd_addr,
	input  logic              wr_en,
	input  logic [COL_W-1:0]  wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [MAX_WIDTH];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] byp_data_q;
	logic              byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// a one-pixel-wide image reads the column written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

@@ hdl/nadg_sad.sv @@
// 3x3 window, masked sum of absolute differences and result register.
module nadg_sad import nadg_pkg::*; #(
	parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic [PIXEL_BITS-1:0] older,
	input  logic [PIXEL_BITS-1:0] newer,
	input  logic [PIXEL_BITS-1:0] pixel_s1,
	input  nbr_flags_t            flags_s1,
	input  logic [MASK_W-1:0]     mask,
	output logic                  s2_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_word_t             res
);

	localparam int unsigned SUM_W = PIXEL_BITS + 3;
	localparam int unsigned EXT_W = (SUM_W > GRAD_W) ? SUM_W : GRAD_W;
	localparam int unsigned WIN_CENTRE = 4;

	logic [PIXEL_BITS-1:0] window_q [9];
	nbr_flags_t            flags_s2;
	logic                  valid_s2;
	logic                  valid_s3;
	res_word_t             res_s3;
	logic                  s3_ready;
	logic [SUM_W-1:0]      term [NBR_COUNT];
	logic [SUM_W-1:0]      sum;
	logic [EXT_W-1:0]      sum_ext;
	logic [GRAD_W-1:0]     grad;

	function automatic logic nbr_ok(input int unsigned idx, input nbr_flags_t f);
		logic ok;
		case (idx)
			0:       ok = f.top_ok && f.left_ok;
			1:       ok = f.top_ok;
			2:       ok = f.top_ok && f.right_ok;
			3:       ok = f.left_ok;
			4:       ok = f.right_ok;
			5:       ok = f.bot_ok && f.left_ok;
			6:       ok = f.bot_ok;
			7:       ok = f.bot_ok && f.right_ok;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	assign s3_ready = !valid_s3 || res_ready;
	assign s2_ready = !valid_s2 || s3_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				window_q[i] <= '0;
			end
		end else if (shift) begin
			window_q[0] <= window_q[1];
			window_q[1] <= window_q[2];
			window_q[2] <= older;
			window_q[3] <= window_q[4];
			window_q[4] <= window_q[5];
			window_q[5] <= newer;
			window_q[6] <= window_q[7];
			window_q[7] <= window_q[8];
			window_q[8] <= pixel_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			flags_s2 <= flags_s1;
		end
		if (s3_ready && valid_s2) begin
			res_s3.gradient      <= grad;
			res_s3.last_of_frame <= flags_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= shift && flags_s1.emit;
			end
			if (s3_ready) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_comb begin : p_sum
		logic [PIXEL_BITS-1:0] centre;
		logic [PIXEL_BITS-1:0] v;
		logic [PIXEL_BITS-1:0] diff;
		centre = window_q[WIN_CENTRE];
		for (int unsigned i = 0; i < NBR_COUNT; i++) begin
			// skip the centre slot of the window
			v       = window_q[4'((i < WIN_CENTRE) ? i : i + 1)];
			diff    = (centre > v) ? centre - v : v - centre;
			term[i] = (mask[i] && nbr_ok(i, flags_s2)) ? SUM_W'(diff) : '0;
		end
		sum = ((term[0] + term[1]) + (term[2] + term[3])) +
			((term[4] + term[5]) + (term[6] + term[7]));
	end

	// clamp only matters for pixels wider than 16 bits
	assign sum_ext = EXT_W'(sum);
	assign grad    = (sum_ext > EXT_W'(GRAD_MAX)) ? GRAD_MAX : sum_ext[GRAD_W-1:0];

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule

@@ hdl/nadg_checker.sv @@
// Port-level checks for the gradient block, bound to the top level.
module nadg_checker import nadg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pix_valid,
	input logic      pix_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_word_t res
);

	// reset empties the result register
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// input backs up only behind a held result
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid || res_ready) |-> pix_ready)
		else $error("input stalled while result side free");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before taken");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result word changed while stalled");

endmodule

bind neighbour_abs_diff_gradient nadg_checker u_nadg_checker (.*);
